// File: hdl/mcwm_pkg.sv
// Shared types and constants for the multi-channel window mean block.
package mcwm_pkg;

  localparam int KIND_W    = 2;
  localparam int CHANNEL_W = 6;
  localparam int SAMPLE_W  = 24;
  localparam int MEAN_W    = 32;
  localparam int FRAC_W    = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_ACTIVATE   = 2'd1,
    KIND_DEACTIVATE = 2'd2,
    KIND_REPORT     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [CHANNEL_W-1:0]  channel;
    logic [SAMPLE_W-1:0]   sample;
  } cmd_t;

endpackage

// File: hdl/mcwm_front.sv
// Input stage: accepts words, drops out-of-range channel commands, queues the rest.
module mcwm_front #(
  parameter int CHANNELS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mcwm_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [mcwm_pkg::KIND_W-1:0]        in_tuser,
  output logic                               cmd_valid,
  output mcwm_pkg::cmd_t                     cmd,
  input  logic                               cmd_pop
);

  localparam int CW    = mcwm_pkg::CHANNEL_W;
  localparam int SW    = mcwm_pkg::SAMPLE_W;
  localparam int DEPTH = 4;
  localparam int PTR_W = 2;
  localparam logic [CW-1:0] CH_LIMIT = CW'(CHANNELS);

  mcwm_pkg::cmd_t        queue_r [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r;
  logic [PTR_W-1:0]      rd_ptr_r;
  logic [PTR_W:0]        count_r;
  mcwm_pkg::cmd_t        in_cmd;
  logic                  keep;
  logic                  push;
  logic                  pop;

  always_comb begin
    in_cmd.kind    = mcwm_pkg::kind_t'(in_tuser);
    in_cmd.channel = in_tdata[CW-1:0];
    in_cmd.sample  = in_tdata[CW+SW-1:CW];
  end

  assign keep      = (in_cmd.kind == mcwm_pkg::KIND_REPORT) || (in_cmd.channel < CH_LIMIT);
  assign in_tready = (count_r != (PTR_W+1)'(DEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// File: hdl/mcwm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module mcwm_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

endmodule

// File: hdl/mcwm_back.sv
// Execution stage: per-channel windows, sample ring memory, report sequencer and output register.
module mcwm_back #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_valid,
  input  mcwm_pkg::cmd_t                     cmd,
  output logic                               cmd_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mcwm_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int CW     = mcwm_pkg::CHANNEL_W;
  localparam int SW     = mcwm_pkg::SAMPLE_W;
  localparam int MW     = mcwm_pkg::MEAN_W;
  localparam int FW     = mcwm_pkg::FRAC_W;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = SW + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(CHANNELS + 1);
  localparam int TOT_W  = MW + CNT_W;
  localparam int NUM_W  = (SUM_W + FW > TOT_W) ? SUM_W + FW : TOT_W;
  localparam int DEN_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;
  localparam int RING_DEPTH = CHANNELS * WINDOW;
  localparam int ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMP_RD,
    ST_SMP_UPD,
    ST_CTRL,
    ST_CH,
    ST_CH_DIV,
    ST_OVR,
    ST_OVR_DIV,
    ST_EMIT
  } state_t;

  state_t             state_r;
  mcwm_pkg::cmd_t     cmd_r;
  logic [HEAD_W-1:0]  head_r   [CHANNELS];
  logic [FILL_W-1:0]  fill_r   [CHANNELS];
  logic [SUM_W-1:0]   sum_r    [CHANNELS];
  logic               active_r [CHANNELS];
  logic [SW-1:0]      ring_mem [RING_DEPTH];
  logic [SW-1:0]      rd_data_r;
  logic [CH_W-1:0]    ch_idx_r;
  logic [TOT_W-1:0]   total_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MW-1:0]      res_mean_r;
  logic               res_valid_r;
  logic               res_ovr_r;
  logic               out_valid_r;
  logic [CW-1:0]      out_channel_r;
  logic [MW-1:0]      out_mean_r;
  logic               out_mvalid_r;
  logic               out_ovr_r;

  logic [CH_W-1:0]    sel_ch;
  logic [HEAD_W-1:0]  cur_head;
  logic [FILL_W-1:0]  cur_fill;
  logic [SUM_W-1:0]   cur_sum;
  logic [ADDR_W-1:0]  ring_addr;
  logic               full;
  logic [SUM_W-1:0]   sum_add;
  logic [SUM_W-1:0]   sum_nxt;
  logic [HEAD_W-1:0]  head_nxt;
  logic               out_free;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;

  assign sel_ch    = (cmd_r.kind == mcwm_pkg::KIND_REPORT) ? ch_idx_r : cmd_r.channel[CH_W-1:0];
  assign cur_head  = head_r[sel_ch];
  assign cur_fill  = fill_r[sel_ch];
  assign cur_sum   = sum_r[sel_ch];
  assign ring_addr = ADDR_W'(sel_ch) * ADDR_W'(WINDOW) + ADDR_W'(cur_head);
  assign full      = (cur_fill == FILL_W'(WINDOW));
  assign sum_add   = cur_sum + SUM_W'(cmd_r.sample);
  assign sum_nxt   = full ? (sum_add - SUM_W'(rd_data_r)) : sum_add;
  assign head_nxt  = (cur_head == HEAD_W'(WINDOW - 1)) ? '0 : cur_head + HEAD_W'(1);
  assign out_free  = !out_valid_r || out_tready;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;

  assign div_start = ((state_r == ST_CH) && (cur_fill != '0)) ||
                     ((state_r == ST_OVR) && (cnt_r != '0));
  assign div_num   = (state_r == ST_OVR) ? NUM_W'(total_r) : NUM_W'({cur_sum, {FW{1'b0}}});
  assign div_den   = (state_r == ST_OVR) ? DEN_W'(cnt_r) : DEN_W'(cur_fill);

  mcwm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_SMP_UPD) begin
      ring_mem[ring_addr] <= cmd_r.sample;
    end
    if (state_r == ST_SMP_RD) begin
      rd_data_r <= ring_mem[ring_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        head_r[i]   <= '0;
        fill_r[i]   <= '0;
        sum_r[i]    <= '0;
        active_r[i] <= 1'b0;
      end
    end else begin
      if (out_tready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            case (cmd.kind)
              mcwm_pkg::KIND_SAMPLE: begin
                state_r <= ST_SMP_RD;
              end
              mcwm_pkg::KIND_REPORT: begin
                ch_idx_r <= '0;
                total_r  <= '0;
                cnt_r    <= '0;
                state_r  <= ST_CH;
              end
              default: begin
                state_r <= ST_CTRL;
              end
            endcase
          end
        end
        ST_SMP_RD: begin
          state_r <= ST_SMP_UPD;
        end
        ST_SMP_UPD: begin
          sum_r[sel_ch]  <= sum_nxt;
          head_r[sel_ch] <= head_nxt;
          if (!full) begin
            fill_r[sel_ch] <= cur_fill + FILL_W'(1);
          end
          state_r <= ST_IDLE;
        end
        ST_CTRL: begin
          if (cmd_r.kind == mcwm_pkg::KIND_ACTIVATE) begin
            active_r[sel_ch] <= 1'b1;
          end else if (active_r[sel_ch]) begin
            active_r[sel_ch] <= 1'b0;
            head_r[sel_ch]   <= '0;
            fill_r[sel_ch]   <= '0;
            sum_r[sel_ch]    <= '0;
          end
          state_r <= ST_IDLE;
        end
        ST_CH: begin
          res_ovr_r <= 1'b0;
          if (cur_fill != '0) begin
            state_r <= ST_CH_DIV;
          end else begin
            res_mean_r  <= '0;
            res_valid_r <= 1'b0;
            state_r     <= ST_EMIT;
          end
        end
        ST_CH_DIV: begin
          if (div_done) begin
            res_mean_r  <= div_quo[MW-1:0];
            res_valid_r <= 1'b1;
            total_r     <= total_r + TOT_W'(div_quo[MW-1:0]);
            cnt_r       <= cnt_r + CNT_W'(1);
            state_r     <= ST_EMIT;
          end
        end
        ST_OVR: begin
          res_ovr_r <= 1'b1;
          if (cnt_r != '0) begin
            state_r <= ST_OVR_DIV;
          end else begin
            res_mean_r  <= '0;
            res_valid_r <= 1'b0;
            state_r     <= ST_EMIT;
          end
        end
        ST_OVR_DIV: begin
          if (div_done) begin
            res_mean_r  <= div_quo[MW-1:0];
            res_valid_r <= 1'b1;
            state_r     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_channel_r <= res_ovr_r ? '0 : CW'(ch_idx_r);
            out_mean_r    <= res_mean_r;
            out_mvalid_r  <= res_valid_r;
            out_ovr_r     <= res_ovr_r;
            if (res_ovr_r) begin
              state_r <= ST_IDLE;
            end else if (ch_idx_r == CH_W'(CHANNELS - 1)) begin
              state_r <= ST_OVR;
            end else begin
              ch_idx_r <= ch_idx_r + CH_W'(1);
              state_r  <= ST_CH;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_mvalid_r, out_mean_r, out_channel_r};
  assign out_tuser  = out_ovr_r;
  assign out_tlast  = out_ovr_r;

endmodule

// File: hdl/multi_channel_window_mean.sv
// Top level of the multi-channel window mean block.
//
// Input words carry a command kind on in_tuser and a channel and a sample on in_tdata.
// Sample words push a value into the channel's window of the latest WINDOW samples;
// activate and deactivate words change a channel's active flag, and deactivating an
// active channel empties its window. Words for channels at or above CHANNELS are
// accepted and dropped. A report word produces CHANNELS + 1 output words: each
// channel's mean, then the mean of the valid channel means, marked by out_tuser and
// out_tlast. Means carry 8 fraction bits and are truncated.
// A four-word command queue sits between the input and the executing sequencer.
// A sample passes through a ring read and a window update, an activate or deactivate
// through a control state. A report visits each channel and then the overall mean,
// using the shared N-bit bit-serial divider (N = 36 at the defaults) only where a mean exists.
// Reset clears the queue, the sequencer and all per-channel counts and sums; the
// sample ring memory keeps its contents and needs no clearing pass.
// When the receiver stalls, the output register holds its word, the sequencer waits
// before its next result, and input words are taken until the queue is full.
module multi_channel_window_mean #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // channel[5:0], sample[29:6], zero[31:30]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_channel[5:0], mean_value[37:6], mean_valid[38], zero[39]
  output logic        out_tuser,  // is_overall[0]
  output logic        out_tlast
);

  mcwm_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_pop;

  mcwm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop)
  );

  mcwm_back #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_full_queue_has_work: assert property (
    @(posedge clk) disable iff (!rst_n) !in_tready |-> q_valid
  ) else $error("input stalled while the command queue is empty");

  a_overall_word: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[5:0] == 6'd0) && out_tlast
  ) else $error("overall result without channel zero or end of report");

  a_invalid_mean_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[38]) |-> (out_tdata[37:6] == 32'd0)
  ) else $error("invalid mean carries a non-zero value");

endmodule
